FILE: rtl/pmm_pkg.sv
// pmm_pkg: shared constants, codes and control structs of the paged memory manager
// used by the controller, the datapath and the top level; depends on nothing
`timescale 1ns / 1ps

package pmm_pkg;

  // default geometry of the byte store, both sizes powers of two
  localparam int unsigned PMM_MEM_SIZE   = 64;
  localparam int unsigned PMM_FRAME_SIZE = 16;

  // byte value of an erased location and of an empty table slot
  localparam logic [7:0] EMPTY_BYTE = 8'hFF;

  // request op codes
  localparam logic [1:0] OP_MAP   = 2'd0;
  localparam logic [1:0] OP_STORE = 2'd1;
  localparam logic [1:0] OP_LOAD  = 2'd2;

  // result status codes
  localparam logic [3:0] ST_MAPPED    = 4'd0;
  localparam logic [3:0] ST_UPDATED   = 4'd1;
  localparam logic [3:0] ST_STORED    = 4'd2;
  localparam logic [3:0] ST_LOADED    = 4'd3;
  localparam logic [3:0] ST_NOFRAME   = 4'd4;
  localparam logic [3:0] ST_ALREADY   = 4'd5;
  localparam logic [3:0] ST_FULL      = 4'd6;
  localparam logic [3:0] ST_PROTECTED = 4'd7;
  localparam logic [3:0] ST_NOTMAPPED = 4'd8;

  // commands from the controller to the datapath
  typedef struct packed {
    logic       load_req;   // capture the request fields
    logic       fr_clear;   // restart the frame header scan
    logic       fr_inc;     // step to the next frame
    logic       rd_hdr;     // read byte 0 of the current frame
    logic       set_tf_hit; // current frame is the page table
    logic       new_table;  // lowest free frame becomes the page table
    logic       alloc_df;   // lowest free frame becomes the data frame
    logic       free_df;    // release the data frame
    logic       slot_init;  // point at the first table slot
    logic       slot_inc;   // step to the next table slot
    logic       rd_vpn;     // read the slot vpn byte
    logic       rd_rw;      // read the slot rw byte
    logic       rd_pfn;     // read the slot pfn byte
    logic       rd_phys;    // read the translated data byte
    logic       lat_rw;     // keep the rw byte just read
    logic       wr_rw_new;  // write rw byte of a new entry
    logic       wr_rw_upd;  // rewrite bit 0 of the rw byte
    logic       wr_vpn;     // write vpn byte of a new entry
    logic       wr_pfn;     // write pfn byte of a new entry
    logic       wr_data;    // write the store byte
    logic       red_init;   // form the physical address
    logic       set_res;    // load the result register
    logic [3:0] res_status; // status code for the result
    logic       res_data;   // result data from the read byte
    logic       res_pa;     // result address from the physical address
    logic       res_fr_df;  // result frame is the data frame
    logic       res_fr_rd;  // result frame is the read pfn byte
  } pmm_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic [1:0] op;
    logic       fr_end;
    logic       fr_is_table;
    logic       hdr_match;
    logic       free_ok;
    logic       slot_end;
    logic       vpn_match;
    logic       slot_empty;
    logic       rw_eq;
    logic       rw_wr;
  } pmm_stat_t;

endpackage

FILE: rtl/pmm_if.sv
// pmm_req_if and pmm_rsp_if: valid/ready channels of requests and results
// depends on nothing
`timescale 1ns / 1ps

interface pmm_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] op;
  logic [7:0] pid;
  logic [5:0] vaddr;
  logic [7:0] value;

  modport source (output valid, output op, output pid, output vaddr, output value,
                  input ready);
  modport sink (input valid, input op, input pid, input vaddr, input value,
                output ready);
endinterface

interface pmm_rsp_if;
  logic       valid;
  logic       ready;
  logic [3:0] status;
  logic [7:0] data;
  logic [5:0] phys_addr;
  logic [1:0] frame;

  modport source (output valid, output status, output data, output phys_addr,
                  output frame, input ready);
  modport sink (input valid, input status, input data, input phys_addr, input frame,
                output ready);
endinterface

FILE: rtl/pmm_ctrl.sv
// pmm_ctrl: sequencing state machine of the paged memory manager
// depends on pmm_pkg for the command and status structs and the codes
`timescale 1ns / 1ps

module pmm_ctrl import pmm_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  input  pmm_stat_t st_i,
  output pmm_cmd_t  cmd_o
);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_TF_RD    = 4'd1;
  localparam logic [3:0] S_TF_CHK   = 4'd2;
  localparam logic [3:0] S_DF_ALLOC = 4'd3;
  localparam logic [3:0] S_SL_INIT  = 4'd4;
  localparam logic [3:0] S_SL_RD    = 4'd5;
  localparam logic [3:0] S_SL_CHK   = 4'd6;
  localparam logic [3:0] S_RW_CHK   = 4'd7;
  localparam logic [3:0] S_PF_CHK   = 4'd8;
  localparam logic [3:0] S_WR_VPN   = 4'd9;
  localparam logic [3:0] S_WR_PFN   = 4'd10;
  localparam logic [3:0] S_ACC      = 4'd12;
  localparam logic [3:0] S_LD_WAIT  = 4'd13;
  localparam logic [3:0] S_RESP     = 4'd14;

  logic [3:0] state_q, state_d;
  logic       op_map, op_valid;

  assign op_map   = (st_i.op == OP_MAP);
  assign op_valid = (st_i.op == OP_MAP) || (st_i.op == OP_STORE) || (st_i.op == OP_LOAD);

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_req = 1'b1;
          cmd_o.fr_clear = 1'b1;
          state_d        = S_TF_RD;
        end
      end
      S_TF_RD: begin
        if (!op_valid) begin
          cmd_o.set_res    = 1'b1;
          cmd_o.res_status = ST_NOTMAPPED;
          state_d          = S_RESP;
        end else if (st_i.fr_end) begin
          // no table for this pid
          if (op_map && st_i.free_ok) begin
            cmd_o.new_table = 1'b1;
            state_d         = S_DF_ALLOC;
          end else begin
            cmd_o.set_res    = 1'b1;
            cmd_o.res_status = op_map ? ST_NOFRAME : ST_NOTMAPPED;
            state_d          = S_RESP;
          end
        end else if (st_i.fr_is_table) begin
          cmd_o.rd_hdr = 1'b1;
          state_d      = S_TF_CHK;
        end else begin
          cmd_o.fr_inc = 1'b1;
        end
      end
      S_TF_CHK: begin
        if (st_i.hdr_match) begin
          cmd_o.set_tf_hit = 1'b1;
          state_d          = op_map ? S_DF_ALLOC : S_SL_INIT;
        end else begin
          cmd_o.fr_inc = 1'b1;
          state_d      = S_TF_RD;
        end
      end
      S_DF_ALLOC: begin
        if (st_i.free_ok) begin
          cmd_o.alloc_df  = 1'b1;
          cmd_o.slot_init = 1'b1;
          state_d         = S_SL_RD;
        end else begin
          cmd_o.set_res    = 1'b1;
          cmd_o.res_status = ST_NOFRAME;
          state_d          = S_RESP;
        end
      end
      S_SL_INIT: begin
        cmd_o.slot_init = 1'b1;
        state_d         = S_SL_RD;
      end
      S_SL_RD: begin
        if (st_i.slot_end) begin
          // every slot looked at without a hit
          cmd_o.set_res    = 1'b1;
          cmd_o.free_df    = op_map;
          cmd_o.res_status = op_map ? ST_FULL : ST_NOTMAPPED;
          state_d          = S_RESP;
        end else begin
          cmd_o.rd_vpn = 1'b1;
          state_d      = S_SL_CHK;
        end
      end
      S_SL_CHK: begin
        if (st_i.vpn_match) begin
          cmd_o.rd_rw = 1'b1;
          state_d     = S_RW_CHK;
        end else if (st_i.slot_empty && op_map) begin
          cmd_o.wr_rw_new = 1'b1;
          state_d         = S_WR_VPN;
        end else begin
          cmd_o.slot_inc = 1'b1;
          state_d        = S_SL_RD;
        end
      end
      S_RW_CHK: begin
        cmd_o.lat_rw = 1'b1;
        cmd_o.rd_pfn = 1'b1;
        state_d      = S_PF_CHK;
      end
      S_PF_CHK: begin
        if (op_map) begin
          // existing entry: the spare data frame goes back
          cmd_o.free_df    = 1'b1;
          cmd_o.set_res    = 1'b1;
          cmd_o.res_fr_rd  = 1'b1;
          cmd_o.wr_rw_upd  = !st_i.rw_eq;
          cmd_o.res_status = st_i.rw_eq ? ST_ALREADY : ST_UPDATED;
          state_d          = S_RESP;
        end else begin
          cmd_o.red_init = 1'b1;
          state_d        = S_ACC;
        end
      end
      S_ACC: begin
        if (st_i.op == OP_STORE) begin
          cmd_o.set_res = 1'b1;
          if (st_i.rw_wr) begin
            cmd_o.wr_data    = 1'b1;
            cmd_o.res_pa     = 1'b1;
            cmd_o.res_status = ST_STORED;
          end else begin
            cmd_o.res_status = ST_PROTECTED;
          end
          state_d = S_RESP;
        end else begin
          cmd_o.rd_phys = 1'b1;
          state_d       = S_LD_WAIT;
        end
      end
      S_LD_WAIT: begin
        cmd_o.set_res    = 1'b1;
        cmd_o.res_data   = 1'b1;
        cmd_o.res_pa     = 1'b1;
        cmd_o.res_status = ST_LOADED;
        state_d          = S_RESP;
      end
      S_WR_VPN: begin
        cmd_o.wr_vpn = 1'b1;
        state_d      = S_WR_PFN;
      end
      S_WR_PFN: begin
        cmd_o.wr_pfn     = 1'b1;
        cmd_o.set_res    = 1'b1;
        cmd_o.res_fr_df  = 1'b1;
        cmd_o.res_status = ST_MAPPED;
        state_d          = S_RESP;
      end
      S_RESP: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/pmm_datapath.sv
// pmm_datapath: byte store, frame flags, scan counters, address translation and result register
// depends on pmm_pkg for the command and status structs and the default sizes and erased byte value
`timescale 1ns / 1ps

module pmm_datapath import pmm_pkg::*; #(
  parameter int unsigned MEM_SIZE   = PMM_MEM_SIZE,
  parameter int unsigned FRAME_SIZE = PMM_FRAME_SIZE
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  pmm_cmd_t   cmd_i,
  output pmm_stat_t  st_o,
  input  logic [1:0] op_i,
  input  logic [7:0] pid_i,
  input  logic [5:0] vaddr_i,
  input  logic [7:0] value_i,
  output logic [3:0] status_o,
  output logic [7:0] data_o,
  output logic [5:0] phys_addr_o,
  output logic [1:0] frame_o
);

  localparam int unsigned NFRAMES = MEM_SIZE / FRAME_SIZE;
  localparam int unsigned NSLOTS  = (FRAME_SIZE - 1) / 3;
  localparam int unsigned AW      = $clog2(MEM_SIZE);
  localparam int unsigned FW      = (NFRAMES > 1) ? $clog2(NFRAMES) : 1;
  localparam int unsigned FCW     = $clog2(NFRAMES + 1);
  localparam int unsigned SCW     = $clog2(NSLOTS + 1);

  // request fields
  logic [1:0]     op_q;
  logic [7:0]     pid_q;
  logic [1:0]     vpn_q;
  logic [3:0]     off_q;
  logic [7:0]     val_q;

  // frame flags and byte store
  logic [NFRAMES-1:0] used_q;
  logic [NFRAMES-1:0] table_q;
  logic [7:0]         mem_q [MEM_SIZE];
  logic [MEM_SIZE-1:0] mem_vld_q;
  logic [7:0]         rd_q;
  logic               rvld_q;
  logic [7:0]         rd_byte;

  // scan state
  logic [FCW-1:0] fcnt_q;
  logic [FW-1:0]  fidx;
  logic [FW-1:0]  tf_q;
  logic [FW-1:0]  df_q;
  logic [SCW-1:0] scnt_q;
  logic [AW-1:0]  e_q;
  logic [7:0]     rw_q;

  // physical address
  logic [AW-1:0]  rem_q;

  // result register
  logic [3:0]     res_status_q;
  logic [7:0]     res_data_q;
  logic [5:0]     res_pa_q;
  logic [1:0]     res_frame_q;

  // lowest free frame
  logic           free_ok;
  logic [FW-1:0]  free_idx;

  // store ports
  logic           re, we;
  logic [AW-1:0]  raddr, waddr;
  logic [7:0]     wdata;
  logic [AW-1:0]  hdr_addr, tf_base, free_base;

  assign fidx      = fcnt_q[FW-1:0];
  assign hdr_addr  = AW'(fidx * FRAME_SIZE);
  assign tf_base   = AW'(tf_q * FRAME_SIZE);
  assign free_base = AW'(free_idx * FRAME_SIZE);
  // bytes never written still hold the erased value
  assign rd_byte   = rvld_q ? rd_q : EMPTY_BYTE;

  // priority pick of the lowest unused frame
  always_comb begin
    free_ok  = 1'b0;
    free_idx = '0;
    for (int f = NFRAMES - 1; f >= 0; f--) begin
      if (!used_q[f]) begin
        free_ok  = 1'b1;
        free_idx = FW'(f);
      end
    end
  end

  // read and write address selection
  always_comb begin
    re    = cmd_i.rd_hdr | cmd_i.rd_vpn | cmd_i.rd_rw | cmd_i.rd_pfn | cmd_i.rd_phys;
    raddr = e_q;
    if (cmd_i.rd_hdr) begin
      raddr = hdr_addr;
    end else if (cmd_i.rd_vpn) begin
      raddr = e_q + AW'(1);
    end else if (cmd_i.rd_pfn) begin
      raddr = e_q + AW'(2);
    end else if (cmd_i.rd_phys) begin
      raddr = rem_q;
    end

    we    = cmd_i.new_table | cmd_i.wr_rw_new | cmd_i.wr_rw_upd | cmd_i.wr_vpn |
            cmd_i.wr_pfn | cmd_i.wr_data;
    waddr = e_q;
    wdata = {7'b0, val_q[0]};
    if (cmd_i.new_table) begin
      waddr = free_base;
      wdata = pid_q;
    end else if (cmd_i.wr_rw_upd) begin
      wdata = {rw_q[7:1], val_q[0]};
    end else if (cmd_i.wr_vpn) begin
      waddr = e_q + AW'(1);
      wdata = 8'(vpn_q);
    end else if (cmd_i.wr_pfn) begin
      waddr = e_q + AW'(2);
      wdata = 8'(df_q);
    end else if (cmd_i.wr_data) begin
      waddr = rem_q;
      wdata = val_q;
    end
  end

  // byte store with registered read
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    if (re) begin
      rd_q   <= mem_q[raddr];
      rvld_q <= mem_vld_q[raddr];
    end
  end

  // written marks and frame flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mem_vld_q <= '0;
      used_q    <= '0;
      table_q   <= '0;
    end else begin
      if (we) begin
        mem_vld_q[waddr] <= 1'b1;
      end
      if (cmd_i.new_table) begin
        used_q[free_idx]  <= 1'b1;
        table_q[free_idx] <= 1'b1;
      end
      if (cmd_i.alloc_df) begin
        used_q[free_idx] <= 1'b1;
      end
      if (cmd_i.free_df) begin
        used_q[df_q] <= 1'b0;
      end
    end
  end

  // request capture, scan counters, physical address and result
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      op_q  <= op_i;
      pid_q <= pid_i;
      vpn_q <= vaddr_i[5:4];
      off_q <= vaddr_i[3:0];
      val_q <= value_i;
    end
    if (cmd_i.fr_clear) begin
      fcnt_q <= '0;
    end else if (cmd_i.fr_inc) begin
      fcnt_q <= fcnt_q + FCW'(1);
    end
    if (cmd_i.set_tf_hit) begin
      tf_q <= fidx;
    end else if (cmd_i.new_table) begin
      tf_q <= free_idx;
    end
    if (cmd_i.alloc_df) begin
      df_q <= free_idx;
    end
    if (cmd_i.slot_init) begin
      e_q    <= tf_base + AW'(1);
      scnt_q <= '0;
    end else if (cmd_i.slot_inc) begin
      e_q    <= e_q + AW'(3);
      scnt_q <= scnt_q + SCW'(1);
    end
    if (cmd_i.lat_rw) begin
      rw_q <= rd_byte;
    end
    // pfn * FRAME_SIZE + offset, wrapped at the power-of-two store size
    if (cmd_i.red_init) begin
      rem_q <= AW'(rd_byte) * AW'(FRAME_SIZE) + AW'(off_q);
    end
    if (cmd_i.set_res) begin
      res_status_q <= cmd_i.res_status;
      res_data_q   <= cmd_i.res_data ? rd_byte : 8'd0;
      res_pa_q     <= cmd_i.res_pa ? 6'(rem_q) : 6'd0;
      if (cmd_i.res_fr_df) begin
        res_frame_q <= 2'(df_q);
      end else if (cmd_i.res_fr_rd) begin
        res_frame_q <= rd_byte[1:0];
      end else begin
        res_frame_q <= 2'd0;
      end
    end
  end

  // status towards the controller
  always_comb begin
    st_o             = '0;
    st_o.op          = op_q;
    st_o.fr_end      = (fcnt_q == FCW'(NFRAMES));
    st_o.fr_is_table = table_q[fidx];
    st_o.hdr_match   = (rd_byte == pid_q);
    st_o.free_ok     = free_ok;
    st_o.slot_end    = (scnt_q == SCW'(NSLOTS));
    st_o.vpn_match   = (rd_byte == 8'(vpn_q));
    st_o.slot_empty  = (rd_byte == EMPTY_BYTE);
    st_o.rw_eq       = (rw_q[0] == val_q[0]);
    st_o.rw_wr       = rw_q[0];
  end

  assign status_o    = res_status_q;
  assign data_o      = res_data_q;
  assign phys_addr_o = res_pa_q;
  assign frame_o     = res_frame_q;

`ifndef SYNTHESIS
  a_no_port_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (re && we) |-> (raddr != waddr))
    else $error("read and write of the same byte in one cycle");
  a_alloc_has_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.alloc_df || cmd_i.new_table) |-> free_ok)
    else $error("frame taken while none is free");
  a_free_owned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.free_df |-> used_q[df_q])
    else $error("released data frame was not in use");
  a_phys_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.rd_phys || cmd_i.wr_data) |-> (32'(rem_q) < MEM_SIZE))
    else $error("physical address outside the store");
`endif

endmodule

FILE: rtl/paged_memory_manager_unit.sv
// paged_memory_manager_unit: top level, controller and datapath on two valid/ready channels
// sequence: an unused op is answered at once from the first scan state; other ops scan the frame
// headers, then the table slots, then the entry or data byte; at most one registered store read per cycle
// throughput: one request at a time, the next is taken the cycle after the result transaction
// reset: frame flags and written marks clear at once, so every byte reads 255; ready right away
`timescale 1ns / 1ps

module paged_memory_manager_unit import pmm_pkg::*; #(
  parameter int unsigned MEM_SIZE   = PMM_MEM_SIZE,
  parameter int unsigned FRAME_SIZE = PMM_FRAME_SIZE
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  pmm_req_if.sink   req_i,
  pmm_rsp_if.source rsp_o
);

  pmm_cmd_t  cmd;
  pmm_stat_t st;

  // sequencing
  pmm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .st_i        (st),
    .cmd_o       (cmd)
  );

  // storage and arithmetic
  pmm_datapath #(
    .MEM_SIZE   (MEM_SIZE),
    .FRAME_SIZE (FRAME_SIZE)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .st_o        (st),
    .op_i        (req_i.op),
    .pid_i       (req_i.pid),
    .vaddr_i     (req_i.vaddr),
    .value_i     (req_i.value),
    .status_o    (rsp_o.status),
    .data_o      (rsp_o.data),
    .phys_addr_o (rsp_o.phys_addr),
    .frame_o     (rsp_o.frame)
  );

endmodule
